/* sv/tgarle_pkg.sv */
// Shared types and constants of the TGA run-length pixel decoder.
// No dependencies; the other files of the block that use it refer to it by scoped names.
package tgarle_pkg;

    localparam int unsigned CFG_IDX_W  = 3;
    localparam int unsigned CFG_DATA_W = 16;
    localparam int unsigned DIM_W      = 16;
    localparam int unsigned PIX_CNT_W  = 32;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] CFG_COMPRESSED = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_BPP        = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_WIDTH      = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_HEIGHT     = 3'd3;

    // Only a pixel size of four bytes is special; any other code means three.
    localparam logic [2:0] BPP_WIDE  = 3'd4;
    localparam logic [2:0] BPP_RESET = 3'd3;

    typedef struct packed {
        logic                 coded;
        logic                 wide_pixel;
    } t_cfg;

    typedef struct packed {
        logic [PIX_CNT_W-1:0] pixels_remaining;
        logic [7:0]           packet_left;
        logic                 packet_is_run;
        logic                 awaiting_header;
        logic [1:0]           byte_in_pixel;
        logic [23:0]          partial_pixel;
    } t_state;

    typedef struct packed {
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
        logic [7:0] alpha;
        logic [7:0] repeat_count;
        logic       last_pixel;
    } t_pix;

    localparam t_state STATE_RESET = '{
        pixels_remaining: '0,
        packet_left:      '0,
        packet_is_run:    1'b0,
        awaiting_header:  1'b1,
        byte_in_pixel:    '0,
        partial_pixel:    '0
    };

    // Limits a pixel count to the pixels still left in the image.
    function automatic logic [7:0] clip_count(input logic [7:0] cnt,
                                              input logic [PIX_CNT_W-1:0] remaining);
        logic [7:0] res;
        begin
            if (remaining < {{(PIX_CNT_W-8){1'b0}}, cnt}) begin
                res = remaining[7:0];
            end else begin
                res = cnt;
            end
            return res;
        end
    endfunction

endpackage

/* sv/tgarle_pix_if.sv */
// Input channel of the decoder: one stream byte per item.
// Depends on nothing.
interface tgarle_pix_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       image_start;

    modport source (output valid, output data_byte, output image_start, input ready);
    modport sink   (input valid, input data_byte, input image_start, output ready);
endinterface

/* sv/tgarle_rgba_if.sv */
// Output channel of the decoder: one decoded pixel with repeat count per item.
// Depends on nothing.
interface tgarle_rgba_if;
    logic       valid;
    logic       ready;
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic [7:0] alpha;
    logic [7:0] repeat_count;
    logic       last_pixel;

    modport source (output valid, output red, output green, output blue, output alpha,
                    output repeat_count, output last_pixel, input ready);
    modport sink   (input valid, input red, input green, input blue, input alpha,
                    input repeat_count, input last_pixel, output ready);
endinterface

/* sv/tgarle_cfg_if.sv */
// Configuration write channel: register index and write data per item.
// Uses the widths of tgarle_pkg.
interface tgarle_cfg_if;
    logic                                valid;
    logic                                ready;
    logic [tgarle_pkg::CFG_IDX_W-1:0]    index;
    logic [tgarle_pkg::CFG_DATA_W-1:0]   data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

/* sv/tgarle_step.sv */
// Per-byte decode step: next decoder state and the pixel that a byte completes.
// Purely combinational; uses the types of tgarle_pkg.
module tgarle_step (
    input  tgarle_pkg::t_cfg                        i_cfg,
    input  logic [tgarle_pkg::PIX_CNT_W-1:0]        i_image_pixels,
    input  tgarle_pkg::t_state                      i_state,
    input  logic [7:0]                              i_data_byte,
    input  logic                                    i_image_start,
    output tgarle_pkg::t_state                      o_next_state,
    output logic                                    o_emit,
    output tgarle_pkg::t_pix                        o_pix
);

    tgarle_pkg::t_state s;
    tgarle_pkg::t_state nxt;
    logic [1:0]         last_idx;
    logic [7:0]         cnt;
    logic [7:0]         alpha;

    always_comb begin
        s = i_state;
        if (i_image_start) begin
            s = tgarle_pkg::STATE_RESET;
            s.pixels_remaining = i_image_pixels;
        end

        nxt      = s;
        o_emit   = 1'b0;
        cnt      = 8'd1;
        alpha    = 8'd0;
        last_idx = i_cfg.wide_pixel ? 2'd3 : 2'd2;

        if (s.pixels_remaining == '0) begin
            // No image active: the byte is dropped.
            nxt = s;
        end else if (i_cfg.coded && s.awaiting_header) begin
            if (!i_data_byte[7]) begin
                nxt.packet_left   = {1'b0, i_data_byte[6:0]} + 8'd1;
                nxt.packet_is_run = 1'b0;
            end else begin
                // Header minus 127 is the low seven bits plus one.
                nxt.packet_left   = tgarle_pkg::clip_count({1'b0, i_data_byte[6:0]} + 8'd1,
                                                           s.pixels_remaining);
                nxt.packet_is_run = 1'b1;
            end
            nxt.awaiting_header = 1'b0;
            nxt.byte_in_pixel   = 2'd0;
        end else if (s.byte_in_pixel < last_idx) begin
            case (s.byte_in_pixel)
                2'd0: nxt.partial_pixel[7:0]   = i_data_byte;
                2'd1: nxt.partial_pixel[15:8]  = i_data_byte;
                2'd2: nxt.partial_pixel[23:16] = i_data_byte;
                default: nxt.partial_pixel = s.partial_pixel;
            endcase
            nxt.byte_in_pixel = s.byte_in_pixel + 2'd1;
        end else begin
            if (i_cfg.wide_pixel) begin
                alpha = i_data_byte;
            end else if (s.byte_in_pixel == 2'd2) begin
                nxt.partial_pixel[23:16] = i_data_byte;
            end
            nxt.byte_in_pixel = 2'd0;

            if (i_cfg.coded && s.packet_is_run) begin
                cnt = (s.packet_left == 8'd0) ? 8'd1 : s.packet_left;
                cnt = tgarle_pkg::clip_count(cnt, s.pixels_remaining);
                nxt.packet_left     = 8'd0;
                nxt.awaiting_header = 1'b1;
            end else if (i_cfg.coded) begin
                if (s.packet_left != 8'd0) begin
                    nxt.packet_left = s.packet_left - 8'd1;
                end
                if (nxt.packet_left == 8'd0) begin
                    nxt.awaiting_header = 1'b1;
                end
            end

            nxt.pixels_remaining = s.pixels_remaining
                                 - {{(tgarle_pkg::PIX_CNT_W-8){1'b0}}, cnt};
            o_emit = 1'b1;
        end

        o_next_state       = nxt;
        o_pix.red          = nxt.partial_pixel[23:16];
        o_pix.green        = nxt.partial_pixel[15:8];
        o_pix.blue         = nxt.partial_pixel[7:0];
        o_pix.alpha        = alpha;
        o_pix.repeat_count = cnt;
        o_pix.last_pixel   = (nxt.pixels_remaining == '0);
    end

endmodule

/* sv/tga_rle_pixel_decoder.sv */
// Top level of the TGA true-color pixel-data decoder, raw or run-length coded.
// Uses tgarle_pkg, the three channel interfaces and tgarle_step.
//
// The block takes the pixel-data bytes of an image on i_pix, one byte per item,
// with image_start raised on the first byte of each image. It gives each completed
// pixel on o_pix as red, green, blue and alpha, with the number of consecutive
// pixels of that color and a mark on the pixel that finishes the image. Bytes
// that arrive while no image is active are dropped without a result.
//
// Configuration arrives on i_cfg (index 0 coded mode, 1 bytes per pixel, 2 width,
// 3 height) and is always ready. Writes must be made while no item is in flight;
// the block does not enforce this. One 16 x 16 multiplier forms the pixel count
// width * height as width or height is written, so none sits in the per-byte path.
//
// Throughput is one byte per cycle while no stalled result blocks the pipe. A byte
// is decoded by the combinational step while it sits in the input register, and
// its pixel, if any, is loaded into the output register as the byte leaves it.
// When the receiver stalls, a result waits in the output register; bytes that
// complete no pixel keep flowing, and the pipe stops only when a byte would
// produce a second result.
// Reset restores the register defaults (coded, 3 bytes, 1 x 1) and leaves no
// image active until the next image_start.
module tga_rle_pixel_decoder (
    input  logic           i_clk,
    input  logic           i_rst_n,
    tgarle_cfg_if.sink     i_cfg,
    tgarle_pix_if.sink     i_pix,
    tgarle_rgba_if.source  o_pix
);

    // Configuration registers.
    logic                               r_cfg_coded;
    logic [2:0]                         r_cfg_bpp;
    logic [tgarle_pkg::DIM_W-1:0]       r_width;
    logic [tgarle_pkg::DIM_W-1:0]       r_height;
    logic [tgarle_pkg::PIX_CNT_W-1:0]   r_image_pixels;
    logic [tgarle_pkg::DIM_W-1:0]       n_width;
    logic [tgarle_pkg::DIM_W-1:0]       n_height;
    logic                               cfg_we;

    // Input register, decoder state and output register.
    logic                               r_in_vld;
    logic [7:0]                         r_in_byte;
    logic                               r_in_start;
    tgarle_pkg::t_state                 r_state;
    logic                               r_out_vld;
    tgarle_pkg::t_pix                   r_out;

    tgarle_pkg::t_cfg                   cfg;
    tgarle_pkg::t_state                 n_state;
    tgarle_pkg::t_pix                   step_pix;
    logic                               step_emit;
    logic                               advance;

    assign i_cfg.ready = 1'b1;
    assign cfg_we      = i_cfg.valid && i_cfg.ready;

    // The multiplier sees the value being written so the count is current at once.
    always_comb begin
        n_width  = r_width;
        n_height = r_height;
        if (cfg_we && (i_cfg.index == tgarle_pkg::CFG_WIDTH)) begin
            n_width = i_cfg.data;
        end
        if (cfg_we && (i_cfg.index == tgarle_pkg::CFG_HEIGHT)) begin
            n_height = i_cfg.data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg_coded    <= 1'b1;
            r_cfg_bpp      <= tgarle_pkg::BPP_RESET;
            r_width        <= 16'd1;
            r_height       <= 16'd1;
            r_image_pixels <= 32'd1;
        end else if (cfg_we) begin
            case (i_cfg.index)
                tgarle_pkg::CFG_COMPRESSED: r_cfg_coded <= i_cfg.data[0];
                tgarle_pkg::CFG_BPP:        r_cfg_bpp   <= i_cfg.data[2:0];
                tgarle_pkg::CFG_WIDTH:      r_width     <= i_cfg.data;
                tgarle_pkg::CFG_HEIGHT:     r_height    <= i_cfg.data;
                default:                    r_cfg_coded <= r_cfg_coded;
            endcase
            r_image_pixels <= 32'(n_width) * 32'(n_height);
        end
    end

    assign cfg = '{coded:      r_cfg_coded,
                   wide_pixel: (r_cfg_bpp == tgarle_pkg::BPP_WIDE)};

    tgarle_step u_step (
        .i_cfg          (cfg),
        .i_image_pixels (r_image_pixels),
        .i_state        (r_state),
        .i_data_byte    (r_in_byte),
        .i_image_start  (r_in_start),
        .o_next_state   (n_state),
        .o_emit         (step_emit),
        .o_pix          (step_pix)
    );

    // A byte leaves the input register unless it makes a pixel while the
    // output register still holds one that is not taken.
    assign advance     = r_in_vld && (!step_emit || !r_out_vld || o_pix.ready);
    assign i_pix.ready = !r_in_vld || advance;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld <= 1'b0;
        end else if (i_pix.ready) begin
            r_in_vld <= i_pix.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_pix.valid && i_pix.ready) begin
            r_in_byte  <= i_pix.data_byte;
            r_in_start <= i_pix.image_start;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= tgarle_pkg::STATE_RESET;
        end else if (advance) begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (advance && step_emit) begin
            r_out_vld <= 1'b1;
        end else if (o_pix.ready) begin
            r_out_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance && step_emit) begin
            r_out <= step_pix;
        end
    end

    assign o_pix.valid        = r_out_vld;
    assign o_pix.red          = r_out.red;
    assign o_pix.green        = r_out.green;
    assign o_pix.blue         = r_out.blue;
    assign o_pix.alpha        = r_out.alpha;
    assign o_pix.repeat_count = r_out.repeat_count;
    assign o_pix.last_pixel   = r_out.last_pixel;

endmodule

/* sv/tgarle_checker.sv */
// Port-level checks for the TGA run-length pixel decoder.
// Bound to tga_rle_pixel_decoder; sees only its ports.
module tgarle_checker (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       i_in_ready,
    input logic       i_out_valid,
    input logic       i_out_ready,
    input logic [7:0] i_out_red,
    input logic [7:0] i_out_green,
    input logic [7:0] i_out_blue,
    input logic [7:0] i_out_alpha,
    input logic [7:0] i_out_count,
    input logic       i_out_last
);

    // A stalled result keeps its pixel.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid
            && $stable({i_out_red, i_out_green, i_out_blue, i_out_alpha,
                        i_out_count, i_out_last}))
        else $error("stalled result changed");

    // Every result covers between one and 128 pixels.
    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> (i_out_count != 8'd0) && (i_out_count <= 8'd128))
        else $error("repeat count out of range");

    // With the output register empty, the input side never stalls.
    a_no_false_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_out_valid |-> i_in_ready)
        else $error("input stalled with empty output");

    // The cycle after reset holds no result.
    a_reset_empty: assert property (@(posedge i_clk)
        i_rst_n && $past(!i_rst_n) |-> !i_out_valid)
        else $error("result present after reset");

endmodule

bind tga_rle_pixel_decoder tgarle_checker u_tgarle_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_ready  (i_pix.ready),
    .i_out_valid (o_pix.valid),
    .i_out_ready (o_pix.ready),
    .i_out_red   (o_pix.red),
    .i_out_green (o_pix.green),
    .i_out_blue  (o_pix.blue),
    .i_out_alpha (o_pix.alpha),
    .i_out_count (o_pix.repeat_count),
    .i_out_last  (o_pix.last_pixel)
);
